@@ rtl/avsc_pkg.sv @@
// Package for the audio volume sample conditioner.
// Holds the item mode codes, volume constants and shared structs; depends on nothing.
package avsc_pkg;

  localparam int unsigned SampleWidth = 16;
  localparam int unsigned LevelWidth  = 3;
  localparam int unsigned ShiftWidth  = 4;

  localparam logic [LevelWidth-1:0] MaxLevel   = 3'd4;
  localparam logic [LevelWidth-1:0] ResetLevel = 3'd3;
  localparam logic [LevelWidth-1:0] MuteLevel  = 3'd0;
  localparam logic [LevelWidth-1:0] MinLevel   = 3'd1;

  localparam logic [SampleWidth-1:0] MidCode = 16'h8000;

  typedef enum logic [2:0] {
    MODE_FRAME = 3'd0,
    MODE_CYCLE = 3'd1,
    MODE_INC   = 3'd2,
    MODE_DEC   = 3'd3,
    MODE_MUTE  = 3'd4,
    MODE_SET   = 3'd5
  } mode_t;

  typedef enum logic {
    SINK_SPEAKER  = 1'b0,
    SINK_EXTERNAL = 1'b1
  } sink_t;

  typedef enum logic {
    REG_SINK_SELECT   = 1'b0,
    REG_DOWNMIX_SHIFT = 1'b1
  } reg_index_t;

  typedef struct packed {
    sink_t                 sink_select;
    logic [ShiftWidth-1:0] downmix_shift;
  } cfg_t;

  typedef struct packed {
    logic [LevelWidth-1:0] volume_level;
    logic [LevelWidth-1:0] saved_level;
  } vol_state_t;

endpackage

@@ rtl/avsc_cfg_regs.sv @@
// Configuration register file with an APB-style write and read port.
// Depends on avsc_pkg for the register indexes and the configuration struct.
module avsc_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output avsc_pkg::cfg_t      cfg
);
  import avsc_pkg::*;

  logic       wr_en;
  reg_index_t wr_index;

  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite && pready;
  assign wr_index = reg_index_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sink_select   <= SINK_SPEAKER;
      cfg.downmix_shift <= 4'd1;
    end else if (wr_en) begin
      case (wr_index)
        REG_SINK_SELECT:   cfg.sink_select   <= sink_t'(pwdata[0]);
        REG_DOWNMIX_SHIFT: cfg.downmix_shift <= pwdata[ShiftWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index_t'(paddr[2]))
      REG_SINK_SELECT:   prdata = {31'd0, cfg.sink_select};
      REG_DOWNMIX_SHIFT: prdata = {{(32-ShiftWidth){1'b0}}, cfg.downmix_shift};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

@@ rtl/avsc_volume_ctrl.sv @@
// Volume state keeper: holds the current and saved levels and applies commands.
// Depends on avsc_pkg for mode codes, level constants and the state struct.
module avsc_volume_ctrl (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               advance,
  input  logic [2:0]                         mode,
  input  logic [avsc_pkg::LevelWidth-1:0]    new_level,
  output avsc_pkg::vol_state_t               state,
  output avsc_pkg::vol_state_t               state_next,
  output logic                               range_error
);
  import avsc_pkg::*;

  logic [LevelWidth-1:0] base;

  assign base = (state.volume_level == MuteLevel) ? state.saved_level : state.volume_level;

  always_comb begin
    state_next  = state;
    range_error = 1'b0;
    case (mode_t'(mode))
      MODE_CYCLE: begin
        state_next.volume_level = (state.volume_level >= MaxLevel) ? MuteLevel
                                  : state.volume_level + 3'd1;
      end
      MODE_INC: begin
        state_next.volume_level = (base >= MaxLevel) ? MaxLevel : base + 3'd1;
        state_next.saved_level  = MuteLevel;
      end
      MODE_DEC: begin
        state_next.volume_level = (base <= MinLevel) ? MinLevel : base - 3'd1;
        state_next.saved_level  = MuteLevel;
      end
      MODE_MUTE: begin
        if (state.volume_level == MuteLevel) begin
          state_next.volume_level = state.saved_level;
          state_next.saved_level  = MuteLevel;
        end else begin
          state_next.saved_level  = state.volume_level;
          state_next.volume_level = MuteLevel;
        end
      end
      MODE_SET: begin
        if (new_level > MaxLevel) begin
          range_error = 1'b1;
        end else begin
          state_next.volume_level = new_level;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.volume_level <= ResetLevel;
      state.saved_level  <= MuteLevel;
    end else if (advance) begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/avsc_sample_path.sv @@
// Frame datapath: speaker downmix with DAC split, or external DAC scaling by volume.
// Depends on avsc_pkg for widths, sink codes and the configuration struct.
module avsc_sample_path (
  input  avsc_pkg::cfg_t                       cfg,
  input  logic [avsc_pkg::LevelWidth-1:0]      volume_level,
  input  logic signed [avsc_pkg::SampleWidth-1:0] left_sample,
  input  logic signed [avsc_pkg::SampleWidth-1:0] right_sample,
  output logic [avsc_pkg::SampleWidth-1:0]     first_word,
  output logic [avsc_pkg::SampleWidth-1:0]     second_word
);
  import avsc_pkg::*;

  logic signed [SampleWidth:0] sum;
  logic signed [SampleWidth:0] shifted;
  logic [SampleWidth-1:0]      s_code;
  logic [SampleWidth+2:0]      seven_s;
  logic [SampleWidth+1:0]      three_s;
  logic [SampleWidth-1:0]      spk_w1;
  logic [SampleWidth-1:0]      spk_w0;
  logic [SampleWidth-1:0]      ext_left;
  logic [SampleWidth-1:0]      ext_right;

  // Division toward zero by 2^k: add 2^k - 1 to negative values before the shift.
  function automatic logic [SampleWidth-1:0] scale_channel(
    input logic signed [SampleWidth-1:0] x,
    input logic [LevelWidth-1:0]         vol
  );
    logic signed [SampleWidth:0] xe;
    logic signed [SampleWidth:0] r;
    xe = {x[SampleWidth-1], x};
    case (vol)
      3'd0:    r = '0;
      3'd1:    r = (xe + (x[SampleWidth-1] ? 17'sd7 : 17'sd0)) >>> 3;
      3'd2:    r = (xe + (x[SampleWidth-1] ? 17'sd3 : 17'sd0)) >>> 2;
      3'd3:    r = (xe + (x[SampleWidth-1] ? 17'sd1 : 17'sd0)) >>> 1;
      default: r = xe;
    endcase
    return r[SampleWidth-1:0];
  endfunction

  assign sum     = {left_sample[SampleWidth-1], left_sample}
                 + {right_sample[SampleWidth-1], right_sample};
  assign shifted = sum >>> cfg.downmix_shift;
  assign s_code  = shifted[SampleWidth-1:0] ^ MidCode;
  assign seven_s = {3'd0, s_code} * 19'd7 + 19'd4;
  assign three_s = {2'd0, s_code} * 18'd3 + 18'd2;

  always_comb begin
    spk_w0 = s_code;
    case (volume_level)
      3'd0: begin
        spk_w0 = '0;
        spk_w1 = '0;
      end
      3'd1:    spk_w1 = seven_s[SampleWidth+2:3];
      3'd2:    spk_w1 = three_s[SampleWidth+1:2];
      3'd3:    spk_w1 = MidCode;
      default: spk_w1 = ~s_code;
    endcase
  end

  assign ext_left  = scale_channel(left_sample, volume_level);
  assign ext_right = scale_channel(right_sample, volume_level);

  assign first_word  = (cfg.sink_select == SINK_EXTERNAL) ? ext_left  : spk_w1;
  assign second_word = (cfg.sink_select == SINK_EXTERNAL) ? ext_right : spk_w0;

endmodule

@@ rtl/audio_volume_sample_conditioner_top.sv @@
// Audio volume sample conditioner, top level: input register, volume control,
// frame datapath and result register. Depends on avsc_pkg and the avsc_* modules.
//
// The block returns one result per accepted transaction, in order, via the input
// and result registers. Each transaction is either a stereo frame or a volume
// command; a frame uses the volume level in force when it reaches the result
// register, so commands and frames act in the order given. Throughput is set by
// the single pass from the input register to the result register: one transaction
// per cycle while out_ready stays high. Configuration must be written over the
// APB-style port only while the block is idle; the block does not enforce this.
module audio_volume_sample_conditioner_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  mode,
  input  logic signed [15:0] left_sample,
  input  logic signed [15:0] right_sample,
  input  logic [2:0]  new_level,
  input  logic        frame_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] first_word,
  output logic [15:0] second_word,
  output logic [2:0]  volume_now,
  output logic        range_error,
  output logic        last_out
);
  import avsc_pkg::*;

  cfg_t       cfg;
  vol_state_t state;
  vol_state_t state_next;

  logic                          s1_valid;
  logic [2:0]                    s1_mode;
  logic signed [SampleWidth-1:0] s1_left;
  logic signed [SampleWidth-1:0] s1_right;
  logic [LevelWidth-1:0]         s1_level;
  logic                          s1_last;

  logic                   advance;
  logic                   is_frame;
  logic                   err_comb;
  logic [SampleWidth-1:0] w1_comb;
  logic [SampleWidth-1:0] w0_comb;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;
  assign is_frame = (mode_t'(s1_mode) == MODE_FRAME);

  avsc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  avsc_volume_ctrl u_vol (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .mode        (s1_mode),
    .new_level   (s1_level),
    .state       (state),
    .state_next  (state_next),
    .range_error (err_comb)
  );

  avsc_sample_path u_path (
    .cfg          (cfg),
    .volume_level (state.volume_level),
    .left_sample  (s1_left),
    .right_sample (s1_right),
    .first_word   (w1_comb),
    .second_word  (w0_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mode  <= mode;
      s1_left  <= left_sample;
      s1_right <= right_sample;
      s1_level <= new_level;
      s1_last  <= frame_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      first_word  <= is_frame ? w1_comb : '0;
      second_word <= is_frame ? w0_comb : '0;
      volume_now  <= state_next.volume_level;
      range_error <= err_comb;
      last_out    <= is_frame ? s1_last : 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_level_in_range: assert property (@(posedge clk) disable iff (rst)
    state.volume_level <= MaxLevel && state.saved_level <= MaxLevel)
    else $error("volume state left the five-step range");

  a_bad_set_keeps_level: assert property (@(posedge clk) disable iff (rst)
    advance && mode_t'(s1_mode) == MODE_SET && s1_level > MaxLevel
    |=> $stable(state.volume_level) && range_error)
    else $error("out-of-range set changed the level or was not flagged");

  a_mute_from_sound: assert property (@(posedge clk) disable iff (rst)
    advance && mode_t'(s1_mode) == MODE_MUTE && state.volume_level != MuteLevel
    |=> state.volume_level == MuteLevel && volume_now == MuteLevel)
    else $error("mute toggle from a nonzero level did not mute");

  a_empty_stage_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("input stage empty but not ready");
`endif

endmodule

@@ dv/audio_volume_sample_conditioner_top_tb.sv @@
// Self-checking testbench for audio_volume_sample_conditioner_top.
// Drives directed and random frames and volume commands, predicts every result in
// the bench and checks it; depends only on avsc_pkg and the RTL under test.
module audio_volume_sample_conditioner_top_tb;
  import avsc_pkg::*;

  localparam logic [2:0] ModeSpareLo = 3'd6;
  localparam logic [2:0] ModeSpareHi = 3'd7;
  localparam logic signed [15:0] SampleMin = -16'sd32768;
  localparam logic signed [15:0] SampleMax = 16'sd32767;
  localparam int WatchdogLimit = 2000;
  localparam int PhaseCount = 7;
  localparam int PhaseItems = 250;
  localparam int CalmItems = 100;

  typedef struct {
    logic [2:0] mode;
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic [2:0] req;
    logic last;
  } item_t;

  typedef struct {
    logic [15:0] first;
    logic [15:0] second;
    logic [2:0] vol;
    logic err;
    logic last;
  } result_t;

  typedef struct {
    item_t it;
    bit known;
    result_t want;
  } row_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic in_valid;
  logic in_ready;
  logic [2:0] mode;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  logic [2:0] new_level;
  logic frame_last;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] first_word;
  logic [15:0] second_word;
  logic [2:0] volume_now;
  logic range_error;
  logic last_out;

  sink_t sink_track;
  logic [3:0] shift_track;
  logic [2:0] level_track;
  logic [2:0] saved_track;
  result_t pending_results[$];
  row_t directed_rows[$];
  int mismatches = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  audio_volume_sample_conditioner_top u_top (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .left_sample(left_sample),
    .right_sample(right_sample),
    .new_level(new_level),
    .frame_last(frame_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .first_word(first_word),
    .second_word(second_word),
    .volume_now(volume_now),
    .range_error(range_error),
    .last_out(last_out)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [15:0] attenuate(logic signed [15:0] x);
    integer v;
    v = x;
    case (level_track)
      MuteLevel: v = 0;
      MinLevel: v = v / 8;
      3'd2: v = v / 4;
      3'd3: v = v / 2;
      default: ;
    endcase
    return v[15:0];
  endfunction

  function automatic result_t condition_item(item_t it);
    result_t r;
    integer sum;
    logic [15:0] s;
    logic [2:0] base;
    logic [31:0] wide;
    r = '{default: '0};
    base = (level_track == MuteLevel) ? saved_track : level_track;
    case (it.mode)
      MODE_FRAME: begin
        r.last = it.last;
        if (sink_track == SINK_SPEAKER) begin
          sum = (integer'(it.left) + integer'(it.right)) >>> shift_track;
          s = sum[15:0] + MidCode;
          if (level_track != MuteLevel) r.second = s;
          case (level_track)
            MuteLevel: r.first = '0;
            MinLevel: begin
              wide = 32'(s) * 7 + 4;
              r.first = wide[18:3];
            end
            3'd2: begin
              wide = 32'(s) * 3 + 2;
              r.first = wide[17:2];
            end
            3'd3: r.first = MidCode;
            default: r.first = ~s;
          endcase
        end else begin
          r.first = attenuate(it.left);
          r.second = attenuate(it.right);
        end
      end
      MODE_CYCLE: level_track = (level_track >= MaxLevel) ? MuteLevel : level_track + 3'd1;
      MODE_INC: begin
        level_track = (base >= MaxLevel) ? MaxLevel : base + 3'd1;
        saved_track = '0;
      end
      MODE_DEC: begin
        level_track = (base <= MinLevel) ? MinLevel : base - 3'd1;
        saved_track = '0;
      end
      MODE_MUTE: begin
        if (level_track == MuteLevel) begin
          level_track = saved_track;
          saved_track = '0;
        end else begin
          saved_track = level_track;
          level_track = MuteLevel;
        end
      end
      MODE_SET: begin
        if (it.req > MaxLevel) r.err = 1'b1;
        else level_track = it.req;
      end
      default: ;
    endcase
    r.vol = level_track;
    return r;
  endfunction

  task automatic add_row(input logic [2:0] md, input logic signed [15:0] l,
                         input logic signed [15:0] r, input logic [2:0] req, input logic lst,
                         input bit known, input logic [15:0] w1, input logic [15:0] w0,
                         input logic [2:0] vol, input logic err, input logic lo);
    row_t row;
    row.it = '{mode: md, left: l, right: r, req: req, last: lst};
    row.known = known;
    row.want = '{first: w1, second: w0, vol: vol, err: err, last: lo};
    directed_rows.push_back(row);
  endtask

  task automatic send_item(input item_t it, input bit known, input result_t want);
    result_t calc;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(19, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= it.mode;
    left_sample <= it.left;
    right_sample <= it.right;
    new_level <= it.req;
    frame_last <= it.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    calc = condition_item(it);
    pending_results.push_back(known ? want : calc);
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(7))
      0: return SampleMin;
      1: return SampleMax;
      2: return '0;
      3: return -16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic item_t random_item();
    item_t it;
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) it.mode = MODE_FRAME;
    else if (pick < 95) it.mode = 3'($urandom_range(MODE_SET, MODE_CYCLE));
    else it.mode = 3'($urandom_range(ModeSpareHi, ModeSpareLo));
    it.left = pick_sample();
    it.right = pick_sample();
    it.req = 3'($urandom_range(7));
    it.last = 1'($urandom_range(1));
    return it;
  endfunction

  task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
    logic [31:0] readback;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_SINK_SELECT) begin
      sink_track = sink_t'(value[0]);
      readback = {31'b0, sink_track};
    end else begin
      shift_track = value[3:0];
      readback = {28'b0, shift_track};
    end
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata !== readback) begin
      $display("%0t: register %0d readback expected %0h, got %0h", $time, idx, readback,
               prdata);
      mismatches++;
    end
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, got %0h %0h %0h %0h %0h", $time,
                 first_word, second_word, volume_now, range_error, last_out);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        compare_field("first_word", want.first, first_word);
        compare_field("second_word", want.second, second_word);
        compare_field("volume_now", 16'(want.vol), 16'(volume_now));
        compare_field("range_error", 16'(want.err), 16'(range_error));
        compare_field("last_out", 16'(want.last), 16'(last_out));
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(18);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || psel || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sink_t sink_plan[PhaseCount];
    logic [3:0] shift_plan[PhaseCount];
    result_t blank;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid <= 1'b0;
    mode <= MODE_FRAME;
    left_sample <= '0;
    right_sample <= '0;
    new_level <= '0;
    frame_last <= 1'b0;
    sink_track = SINK_SPEAKER;
    shift_track = 4'd1;
    level_track = ResetLevel;
    saved_track = '0;
    blank = '{default: '0};
    sink_plan = '{SINK_SPEAKER, SINK_EXTERNAL, SINK_SPEAKER, SINK_EXTERNAL, SINK_SPEAKER,
                  SINK_EXTERNAL, sink_t'($urandom_range(1))};
    shift_plan = '{4'd0, 4'd15, 4'd15, 4'd0, 4'($urandom), 4'($urandom), 4'($urandom)};

    add_row(MODE_FRAME, 0, 0, 0, 1, 1, 16'h8000, 16'h8000, 3'd3, 0, 1);
    add_row(MODE_FRAME, SampleMax, SampleMax, 0, 0, 1, 16'h8000, 16'hffff, 3'd3, 0, 0);
    add_row(MODE_FRAME, SampleMin, SampleMin, 7, 0, 1, 16'h8000, 16'h0000, 3'd3, 0, 0);
    add_row(MODE_SET, SampleMax, SampleMin, 7, 1, 1, 0, 0, 3'd3, 1, 0);
    add_row(MODE_SET, 0, 0, 5, 0, 1, 0, 0, 3'd3, 1, 0);
    add_row(MODE_SET, 0, 0, 4, 0, 1, 0, 0, 3'd4, 0, 0);
    add_row(MODE_FRAME, SampleMax, SampleMin, 0, 1, 0, 0, 0, 0, 0, 0);
    add_row(MODE_INC, 0, 0, 0, 1, 1, 0, 0, 3'd4, 0, 0);
    add_row(MODE_CYCLE, 0, 0, 0, 0, 1, 0, 0, 3'd0, 0, 0);
    add_row(MODE_FRAME, 1234, -999, 0, 1, 1, 0, 0, 3'd0, 0, 1);
    add_row(MODE_MUTE, 0, 0, 0, 0, 1, 0, 0, 3'd0, 0, 0);
    add_row(MODE_DEC, 0, 0, 0, 0, 1, 0, 0, 3'd1, 0, 0);
    add_row(MODE_FRAME, 12345, -2222, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(MODE_DEC, 0, 0, 0, 0, 1, 0, 0, 3'd1, 0, 0);
    add_row(MODE_SET, 0, 0, 2, 0, 1, 0, 0, 3'd2, 0, 0);
    add_row(MODE_FRAME, -20000, 3000, 0, 1, 0, 0, 0, 0, 0, 0);
    add_row(MODE_MUTE, 0, 0, 0, 0, 1, 0, 0, 3'd0, 0, 0);
    add_row(MODE_INC, 0, 0, 0, 0, 1, 0, 0, 3'd3, 0, 0);
    add_row(MODE_MUTE, 0, 0, 0, 0, 1, 0, 0, 3'd0, 0, 0);
    add_row(MODE_MUTE, 0, 0, 0, 0, 1, 0, 0, 3'd3, 0, 0);
    add_row(MODE_MUTE, 0, 0, 0, 0, 1, 0, 0, 3'd0, 0, 0);
    add_row(MODE_DEC, 0, 0, 0, 0, 1, 0, 0, 3'd2, 0, 0);
    add_row(ModeSpareLo, SampleMax, SampleMax, 7, 1, 1, 0, 0, 3'd2, 0, 0);
    add_row(ModeSpareHi, SampleMin, SampleMin, 7, 1, 1, 0, 0, 3'd2, 0, 0);
    add_row(MODE_CYCLE, 0, 0, 0, 0, 1, 0, 0, 3'd3, 0, 0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    idle_pct = 20;
    stall_pct = 20;
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].it, directed_rows[i].known, directed_rows[i].want);
    end
    in_valid <= 1'b0;

    for (int phase = 0; phase < PhaseCount; phase++) begin
      drain();
      write_reg(REG_SINK_SELECT, 32'(sink_plan[phase]));
      write_reg(REG_DOWNMIX_SHIFT, 32'(shift_plan[phase]));
      if (phase == PhaseCount - 1) begin
        idle_pct = 0;
        stall_pct = 0;
      end else begin
        idle_pct = (phase % 3) * 15;
        stall_pct = ((phase + 1) % 3) * 15;
      end
      repeat ((phase == PhaseCount - 1) ? CalmItems : PhaseItems) begin
        send_item(random_item(), 1'b0, blank);
      end
      in_valid <= 1'b0;
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ audio_volume_sample_conditioner_top.f @@
rtl/avsc_pkg.sv
rtl/avsc_cfg_regs.sv
rtl/avsc_volume_ctrl.sv
rtl/avsc_sample_path.sv
rtl/audio_volume_sample_conditioner_top.sv
dv/audio_volume_sample_conditioner_top_tb.sv
